@@ rtl/core/stw_pkg.sv @@
package stw_pkg;

	localparam int ADDR_SPACE   = 65536;
	localparam int ADDR_W       = 16;
	// walk arithmetic: node + header + fanout + 4 * index + 3 stays below 2^18
	localparam int WALK_W       = 18;
	localparam int HEADER_BYTES = 1;
	localparam int OFFSET_BYTES = 4;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_MOVE    = 2'd2,
		CMD_NOP     = 2'd3
	} stw_cmd_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [ADDR_W-1:0] image_address;
		logic [7:0]        data_byte;
	} stw_in_t;

	typedef struct packed {
		logic              on_trie;
		logic              matched;
		logic [ADDR_W-1:0] node_address;
		logic [7:0]        transition_count;
	} stw_out_t;

endpackage

@@ rtl/core/stw_ram.sv @@
module stw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/serialized_trie_walker.sv @@
// Write or unused code goes straight to the result; restart reads the count byte at 0; a
// move scans the letters in order and, on a hit, reads four offset bytes, checks the
// target and reads its count byte (miss, off trie or leaf: to the result). Throughput:
// one word at a time; the next word is taken once the result is in the output register.
// The image RAM, one byte per cycle on its single read port, sets the pace. Reset: walker
// at the root, valid, fanout zero; image contents undefined until written.
module serialized_trie_walker
	import stw_pkg::*;
#(
	parameter int IMAGE_BYTES = 65536
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  stw_in_t  in_word,
	output logic     out_valid,
	input  logic     out_ready,
	output stw_out_t out_word
);

	// Addressable part of the image: anything at or past it reads as zero.
	localparam int SPAN = (IMAGE_BYTES < ADDR_SPACE) ? IMAGE_BYTES : ADDR_SPACE;
	localparam int AW   = $clog2(SPAN);

	// One-hot sequencer.
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010, // one stored letter compared per cycle
		ST_OFFSET = 6'b000100, // four offset bytes, lowest first
		ST_TARGET = 6'b001000, // add offset, range check, fetch count byte
		ST_FANOUT = 6'b010000, // count byte of the new node arrives
		ST_RESULT = 6'b100000  // wait for room in the output register
	} state_t;

	state_t state_q;

	// Walker state
	logic [ADDR_W-1:0] node_q;
	logic              valid_q;
	logic [7:0]        fan_q;
	logic              hit_q;

	// Per-move working registers
	logic [7:0]        idx_q;
	logic [1:0]        byte_q;
	logic [7:0]        letter_q;
	logic [31:0]       raw_q;
	logic [WALK_W-1:0] off_addr_q;
	logic              rd_oob_q;

	// Output register
	logic     out_valid_q;
	stw_out_t out_q;

	// RAM ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WALK_W-1:0] raddr_w;
	logic [7:0]        ram_rdata;
	logic [7:0]        rbyte;

	logic              accept;
	logic              letter_hit;
	logic              last_letter;
	logic [WALK_W-1:0] letter_base_w;
	logic [WALK_W-1:0] off_first_w;
	logic [WALK_W+15:0] target_w;
	logic              target_bad;
	logic              out_room;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_room = !out_valid_q || out_ready;

	// Writes are taken only in idle and every read belongs to a later word,
	// so a read never overlaps a write to the same byte.
	assign ram_we    = accept && (in_word.command == CMD_WRITE)
	                   && ({1'b0, in_word.image_address} < (ADDR_W+1)'(SPAN));
	assign ram_waddr = in_word.image_address[AW-1:0];

	stw_ram #(
		.WIDTH (8),
		.DEPTH (SPAN)
	) u_image (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_word.data_byte),
		.raddr (raddr_w[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Reads past the span return zero.
	assign rbyte = rd_oob_q ? 8'h00 : ram_rdata;

	// Letter i sits at node + 1 + i; its offset at node + 1 + fanout + 4 * i.
	assign letter_base_w = WALK_W'(node_q) + WALK_W'(HEADER_BYTES);
	assign off_first_w   = letter_base_w + WALK_W'(fan_q)
	                       + WALK_W'(idx_q) * WALK_W'(OFFSET_BYTES);
	assign letter_hit    = (rbyte == letter_q);
	assign last_letter   = ({1'b0, idx_q} + 9'd1) == {1'b0, fan_q};

	// Signed target: node plus sign-extended 32-bit offset.
	assign target_w   = (WALK_W+16)'(node_q) + {{(WALK_W-16){raw_q[31]}}, raw_q};
	assign target_bad = target_w[WALK_W+15] || (target_w >= (WALK_W+16)'(SPAN));

	always_comb begin
		raddr_w = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_word.command == CMD_MOVE) begin
					raddr_w = letter_base_w;
				end
			end
			ST_SCAN: begin
				if (letter_hit) begin
					raddr_w = off_first_w;
				end else begin
					raddr_w = letter_base_w + WALK_W'(idx_q) + WALK_W'(1);
				end
			end
			ST_OFFSET: raddr_w = off_addr_q + WALK_W'(byte_q) + WALK_W'(1);
			ST_TARGET: raddr_w = target_w[WALK_W-1:0];
			default:   raddr_w = '0;
		endcase
	end

	// Control and walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			node_q      <= '0;
			valid_q     <= 1'b1;
			fan_q       <= '0;
			hit_q       <= 1'b0;
			idx_q       <= '0;
			byte_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, else drop the one just taken
			if ((state_q == ST_RESULT) && out_room) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q <= 1'b0;
						idx_q <= '0;
						case (in_word.command)
							CMD_RESTART: state_q <= ST_FANOUT; // count byte at 0
							CMD_MOVE: begin
								if (fan_q == 8'd0) begin
									// off trie or leaf: nothing to match
									node_q  <= '0;
									valid_q <= 1'b0;
									fan_q   <= '0;
									state_q <= ST_RESULT;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_SCAN: begin
					if (letter_hit) begin
						hit_q   <= 1'b1;
						byte_q  <= '0;
						state_q <= ST_OFFSET;
					end else if (last_letter) begin
						node_q  <= '0;
						valid_q <= 1'b0;
						fan_q   <= '0;
						state_q <= ST_RESULT;
					end else begin
						idx_q <= idx_q + 8'd1;
					end
				end
				ST_OFFSET: begin
					byte_q <= byte_q + 2'd1;
					if (byte_q == 2'd3) begin
						state_q <= ST_TARGET;
					end
				end
				ST_TARGET: begin
					if (target_bad) begin
						// hit, but jump lands outside the image
						node_q  <= '0;
						valid_q <= 1'b0;
						fan_q   <= '0;
						state_q <= ST_RESULT;
					end else begin
						node_q  <= target_w[ADDR_W-1:0];
						state_q <= ST_FANOUT;
					end
				end
				ST_FANOUT: begin
					// restart left node_q untouched, so force the root here
					if (!hit_q) begin
						node_q <= '0;
					end
					valid_q <= 1'b1;
					fan_q   <= rbyte;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_room) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset
	always_ff @(posedge clk) begin
		rd_oob_q <= (raddr_w >= WALK_W'(SPAN));
		if (accept) begin
			letter_q <= in_word.data_byte;
		end
		if ((state_q == ST_SCAN) && letter_hit) begin
			off_addr_q <= off_first_w;
		end
		if (state_q == ST_OFFSET) begin
			raw_q <= {rbyte, raw_q[31:8]};
		end
		if ((state_q == ST_RESULT) && out_room) begin
			out_q.on_trie          <= valid_q;
			out_q.matched          <= hit_q;
			out_q.node_address     <= node_q;
			out_q.transition_count <= fan_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
